FILE: rtl/core/sliding_minmax_trend_window_macros.svh
// assertion macros for the sliding min/max trend window
// used by the checker module, no other dependencies
`ifndef SLIDING_MINMAX_TREND_WINDOW_MACROS_SVH
`define SLIDING_MINMAX_TREND_WINDOW_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SMTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SMTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/smtw_pkg.sv
// shared types and constants for the sliding min/max trend window
// no dependencies
package smtw_pkg;

  localparam int unsigned DEF_COLUMNS = 64;
  localparam int unsigned APB_AW      = 1;

  localparam logic [APB_AW-1:0] REG_BUCKET_ADDR = '0;
  localparam logic [15:0]       BUCKET_RESET    = 16'd60;

  localparam logic signed [15:0] EMPTY_MARK = 16'sh8000;
  localparam logic signed [15:0] READ_MAX   = 16'sd32767;
  localparam logic signed [15:0] READ_MIN   = -16'sd32767;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ANCHOR = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CLOCK   = 2'd1,
    ST_TOO_OLD    = 2'd2,
    ST_ANCHOR_IGN = 2'd3
  } status_e;

  typedef struct packed {
    logic clear;
    logic move;
    logic write;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/smtw_if.sv
// item channel interfaces for the sliding min/max trend window
// no dependencies
interface smtw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        epoch;
  logic signed [31:0] value;

  modport source (output valid, mode, epoch, value, input ready);
  modport sink   (input valid, mode, epoch, value, output ready);
endinterface

interface smtw_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               range_valid;
  logic signed [15:0] range_low;
  logic signed [15:0] range_high;

  modport source (output valid, status, range_valid, range_low, range_high, input ready);
  modport sink   (input valid, status, range_valid, range_low, range_high, output ready);
endinterface

FILE: rtl/core/smtw_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// 32-bit dividend by 16-bit divisor, no package dependencies
module smtw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] dq_q, dq_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dv_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] rem_sh;
  logic        geq;

  assign rem_sh = {rem_q, dq_q[31]};
  assign geq    = rem_sh >= {1'b0, dv_q};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = geq ? 16'(rem_sh - {1'b0, dv_q}) : rem_sh[15:0];
      dq_d  = {dq_q[30:0], geq};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    // zero bucket length counts as one
    if (start_i) dv_q <= (divisor_i == '0) ? 16'd1 : divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: rtl/core/smtw_cell.sv
// one trend column: min and max register, takes its neighbor's pair on a move
// depends on smtw_pkg
module smtw_cell
  import smtw_pkg::*;
#(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [IW-1:0]       wr_idx_i,
  input  logic signed [15:0]  wr_data_i,
  input  logic signed [15:0]  nb_low_i,
  input  logic signed [15:0]  nb_high_i,
  output logic signed [15:0]  low_o,
  output logic signed [15:0]  high_o
);

  logic signed [15:0] low_q, low_d, high_q, high_d;
  logic               hit;

  assign hit = ctrl_i.write && (wr_idx_i == IW'(IDX));

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (ctrl_i.clear) begin
      low_d  = EMPTY_MARK;
      high_d = EMPTY_MARK;
    end else if (ctrl_i.move) begin
      low_d  = nb_low_i;
      high_d = nb_high_i;
    end else if (hit) begin
      if (low_q == EMPTY_MARK) begin
        low_d  = wr_data_i;
        high_d = wr_data_i;
      end else begin
        if (wr_data_i < low_q)  low_d  = wr_data_i;
        if (wr_data_i > high_q) high_d = wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= EMPTY_MARK;
      high_q <= EMPTY_MARK;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

FILE: rtl/core/sliding_minmax_trend_window.sv
// an item is taken only in idle; a cleared, clockless or unused item goes straight to the scan,
// else it passes the bit-serial divider, an evaluate step and the slide (one column per cycle), then
// a scan rotation of all COLUMNS around the cell chain and a done state that registers the result.
// one item at a time: the next item is taken only after the done state has registered the last result.
// reset is asynchronous active low: all columns empty, newest column 0, bucket 60 s.
module sliding_minmax_trend_window
  import smtw_pkg::*;
#(
  parameter int unsigned COLUMNS = DEF_COLUMNS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  smtw_in_if.sink           in_ch,
  smtw_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CW = $clog2(COLUMNS + 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_EVAL, S_SLIDE, S_SCAN, S_DONE} state_e;

  state_e             state_q;
  logic [15:0]        bucket_q;
  logic [1:0]         mode_q;
  logic signed [15:0] samp_q;
  status_e            status_q;
  logic [31:0]        col_q, newest_q;
  logic [CW-1:0]      cnt_q;
  logic               seen_q;
  logic signed [15:0] acc_lo_q, acc_hi_q;
  logic               out_valid_q, out_rv_q;
  logic [1:0]         out_status_q;
  logic signed [15:0] out_lo_q, out_hi_q;

  logic               accept, div_start, div_done;
  logic [31:0]        quotient, diff, age;
  logic signed [15:0] sat;
  cell_ctrl_t         ctrl;
  logic [IW-1:0]      wr_idx;
  logic signed [15:0] low_w  [COLUMNS];
  logic signed [15:0] high_w [COLUMNS];
  logic signed [15:0] feed_lo, feed_hi;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_BUCKET_ADDR) ? {16'd0, bucket_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= BUCKET_RESET;
    end else if (psel && penable && pwrite && paddr == REG_BUCKET_ADDR) begin
      bucket_q <= pwdata[15:0];
    end
  end

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == S_IDLE);
  assign div_start    = accept && in_ch.epoch != '0 &&
                        (in_ch.mode == MODE_ADD || in_ch.mode == MODE_ANCHOR);

  always_comb begin
    if (in_ch.value <= 32'(READ_MIN))      sat = READ_MIN;
    else if (in_ch.value >= 32'(READ_MAX)) sat = READ_MAX;
    else                                   sat = in_ch.value[15:0];
  end

  smtw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_ch.epoch),
    .divisor_i  (bucket_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign diff   = col_q - newest_q;
  assign age    = newest_q - col_q;
  assign wr_idx = IW'(COLUMNS - 1) - age[IW-1:0];

  always_comb begin
    ctrl = '0;
    case (state_q)
      S_IDLE:  ctrl.clear = accept && in_ch.mode == MODE_CLEAR;
      S_EVAL:  ctrl.clear = col_q > newest_q && diff >= 32'(COLUMNS);
      S_SLIDE: begin
        if (cnt_q != '0) ctrl.move = 1'b1;
        else ctrl.write = mode_q == MODE_ADD && age < 32'(COLUMNS);
      end
      S_SCAN:  ctrl.move = 1'b1;
      default: ctrl = '0;
    endcase
  end

  // slide fills the newest column empty, the scan rotates the oldest back in
  assign feed_lo = (state_q == S_SCAN) ? low_w[0]  : EMPTY_MARK;
  assign feed_hi = (state_q == S_SCAN) ? high_w[0] : EMPTY_MARK;

  for (genvar g = 0; g < COLUMNS; g++) begin : g_cell
    smtw_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_idx_i  (wr_idx),
      .wr_data_i (samp_q),
      .nb_low_i  ((g == COLUMNS - 1) ? feed_lo : low_w[(g + 1) % COLUMNS]),
      .nb_high_i ((g == COLUMNS - 1) ? feed_hi : high_w[(g + 1) % COLUMNS]),
      .low_o     (low_w[g]),
      .high_o    (high_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      newest_q     <= '0;
      cnt_q        <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      mode_q       <= MODE_ADD;
      status_q     <= ST_OK;
    end else begin
      if (out_ch.valid && out_ch.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= in_ch.mode;
            samp_q   <= sat;
            status_q <= ST_OK;
            cnt_q    <= '0;
            seen_q   <= 1'b0;
            if (div_start) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_SCAN;
              if (in_ch.mode == MODE_CLEAR) newest_q <= '0;
              else if (in_ch.mode == MODE_ADD) status_q <= ST_NO_CLOCK;
              else if (in_ch.mode == MODE_ANCHOR) status_q <= ST_ANCHOR_IGN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            col_q   <= quotient;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt_q <= '0;
          if (col_q > newest_q) begin
            newest_q <= col_q;
            if (diff < 32'(COLUMNS)) cnt_q <= diff[CW-1:0];
          end
          state_q <= S_SLIDE;
        end
        S_SLIDE: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - CW'(1);
          end else begin
            if (mode_q == MODE_ADD && age >= 32'(COLUMNS)) status_q <= ST_TOO_OLD;
            seen_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (low_w[0] != EMPTY_MARK) begin
            seen_q <= 1'b1;
            if (!seen_q || low_w[0] < acc_lo_q)  acc_lo_q <= low_w[0];
            if (!seen_q || high_w[0] > acc_hi_q) acc_hi_q <= high_w[0];
          end
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(COLUMNS - 1)) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_rv_q     <= seen_q;
            out_lo_q     <= seen_q ? acc_lo_q : 16'sd0;
            out_hi_q     <= seen_q ? acc_hi_q : 16'sd0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.range_valid = out_rv_q;
  assign out_ch.range_low   = out_lo_q;
  assign out_ch.range_high  = out_hi_q;

endmodule

FILE: rtl/core/smtw_checker.sv
// port-level checks on the sliding min/max trend window, bound to the top level
// depends on smtw_pkg and the assertion macro header
`include "sliding_minmax_trend_window_macros.svh"

module smtw_checker
  import smtw_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               range_valid_i,
  input logic signed [15:0] range_low_i,
  input logic signed [15:0] range_high_i
);

  `SMTW_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_i && !range_valid_i, range_low_i == 16'sd0 && range_high_i == 16'sd0, "empty window must report zero range")
  `SMTW_ASSERT_NOW(a_range_order, clk_i, rst_ni, out_valid_i && range_valid_i, range_low_i <= range_high_i && range_low_i != EMPTY_MARK, "range low above high or empty marker")
  `SMTW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "item taken while previous item in work")
  `SMTW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(range_low_i) && $stable(range_high_i), "stalled result changed")

endmodule

bind sliding_minmax_trend_window smtw_checker u_smtw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .range_valid_i (out_ch.range_valid),
  .range_low_i   (out_ch.range_low),
  .range_high_i  (out_ch.range_high)
);

FILE: tb/sv/sliding_minmax_trend_window_test.sv
// self-checking testbench for the sliding min/max trend window
// depends on smtw_pkg, smtw_in_if/smtw_out_if and the sliding_minmax_trend_window rtl
module sliding_minmax_trend_window_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smtw_pkg::*;

  localparam int NCOL = int'(DEF_COLUMNS);
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]         status;
    logic               range_valid;
    logic signed [15:0] range_low;
    logic signed [15:0] range_high;
  } trend_result_t;

  class trend_scoreboard;
    logic [15:0]        bucket_len;
    logic signed [15:0] col_lo[NCOL];
    logic signed [15:0] col_hi[NCOL];
    logic [31:0]        newest;
    trend_result_t      pending[$];
    int                 errors;

    function new();
      bucket_len = BUCKET_RESET;
      newest = '0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < NCOL; i++) begin
        col_lo[i] = EMPTY_MARK;
        col_hi[i] = EMPTY_MARK;
      end
    endfunction

    function void slide(logic [31:0] col);
      logic [31:0] shift;
      shift = col - newest;
      if (shift >= NCOL) begin
        wipe();
      end else begin
        for (int i = 0; i + shift < NCOL; i++) begin
          col_lo[i] = col_lo[i + shift];
          col_hi[i] = col_hi[i + shift];
        end
        for (int i = NCOL - shift; i < NCOL; i++) begin
          col_lo[i] = EMPTY_MARK;
          col_hi[i] = EMPTY_MARK;
        end
      end
      newest = col;
    endfunction

    function void note_item(logic [1:0] mode, logic [31:0] epoch, logic signed [31:0] value);
      trend_result_t r;
      logic [31:0] col, age, div;
      logic signed [15:0] s;
      int idx;
      r = '0;
      div = (bucket_len == 0) ? 32'd1 : {16'd0, bucket_len};
      if (mode == MODE_ADD) begin
        if (epoch == 0) begin
          r.status = ST_NO_CLOCK;
        end else begin
          col = epoch / div;
          if (col > newest) slide(col);
          age = newest - col;
          if (age >= NCOL) begin
            r.status = ST_TOO_OLD;
          end else begin
            idx = NCOL - 1 - age;
            if (value <= -32767) s = READ_MIN;
            else if (value >= 32767) s = READ_MAX;
            else s = value[15:0];
            if (col_lo[idx] == EMPTY_MARK) begin
              col_lo[idx] = s;
              col_hi[idx] = s;
            end else begin
              if (s < col_lo[idx]) col_lo[idx] = s;
              if (s > col_hi[idx]) col_hi[idx] = s;
            end
          end
        end
      end else if (mode == MODE_ANCHOR) begin
        if (epoch == 0) begin
          r.status = ST_ANCHOR_IGN;
        end else begin
          col = epoch / div;
          if (col > newest) slide(col);
        end
      end else if (mode == MODE_CLEAR) begin
        wipe();
        newest = '0;
      end
      for (int i = 0; i < NCOL; i++) begin
        if (col_lo[i] != EMPTY_MARK) begin
          if (!r.range_valid) begin
            r.range_low = col_lo[i];
            r.range_high = col_hi[i];
            r.range_valid = 1'b1;
          end else begin
            if (col_lo[i] < r.range_low) r.range_low = col_lo[i];
            if (col_hi[i] > r.range_high) r.range_high = col_hi[i];
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(trend_result_t got);
      trend_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
        report_mismatch("status", got.status, want.status);
      if (got.range_valid != want.range_valid)
        report_mismatch("range_valid", got.range_valid, want.range_valid);
      if (got.range_low != want.range_low)
        report_mismatch("range_low", got.range_low, want.range_low);
      if (got.range_high != want.range_high)
        report_mismatch("range_high", got.range_high, want.range_high);
    endfunction

    function void report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  smtw_in_if  in_ch();
  smtw_out_if out_ch();

  sliding_minmax_trend_window u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  trend_scoreboard sb;
  int unsigned cycles;
  bit hold_off;      // long receiver stall
  bit no_gaps;       // stretches without idling

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 15);
      if (hold_off) w = 3000;
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      sb.check_result({out_ch.status, out_ch.range_valid, out_ch.range_low,
                       out_ch.range_high});
    end
  end

  task automatic send_item(logic [1:0] mode, logic [31:0] epoch, logic [31:0] value);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 15);
    if (w != 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.epoch <= epoch;
    in_ch.value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_item(mode, epoch, value);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_bucket(logic [15:0] len);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_BUCKET_ADDR;
    pwdata  <= {16'd0, len};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.bucket_len = len;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 80000) - 40000;
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  // mostly advancing timestamps with some old, out-of-range and odd items
  task automatic random_phase(int n, logic [15:0] len);
    logic [31:0] t, ep;
    int k;
    t = $urandom_range(1, 5000) * len;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        t = t + $urandom_range(0, 3 * len);
        send_item(MODE_ADD, t, rand_value());
      end else if (k < 65) begin
        ep = t - $urandom_range(0, 70 * len);
        send_item(MODE_ADD, ep, rand_value());
      end else if (k < 72) begin
        t = t + $urandom_range(0, 20 * len);
        send_item(MODE_ANCHOR, (k < 70) ? t : t - len, rand_value());
      end else if (k < 76) begin
        t = t + $urandom_range(60, 80) * len;
        send_item(MODE_ADD, t, rand_value());
      end else if (k < 80) begin
        send_item(2'($urandom_range(0, 1)), 32'd0, rand_value());
      end else if (k < 82) begin
        send_item(MODE_CLEAR, $urandom(), $urandom());
        t = $urandom_range(1, 5000) * len;
      end else if (k < 84) begin
        send_item(MODE_UNUSED, $urandom(), $urandom());
      end else if (k < 88) begin
        ep = $urandom();
        send_item(2'($urandom_range(0, 1)), ep, rand_value());
        if (ep / len > t / len) t = ep;
      end else begin
        t = t + $urandom_range(0, len);
        send_item(MODE_ADD, t, rand_value());
      end
    end
  endtask

  initial begin
    sb = new();
    hold_off = 1'b0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.epoch = '0;
    in_ch.value = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset bucket length, field extremes and every special case
    send_item(MODE_ADD, 32'd0, 32'd5);
    send_item(MODE_ANCHOR, 32'd0, 32'd0);
    send_item(MODE_ADD, 32'd600, 32'h7fffffff);
    send_item(MODE_ADD, 32'd601, 32'h80000000);
    send_item(MODE_ADD, 32'd659, -32'sd32767);
    send_item(MODE_ADD, 32'd660, 32'd32767);
    send_item(MODE_ADD, 32'd700, -32'sd32768);
    send_item(MODE_ADD, 32'd0 + 600 * 60, 32'd12);
    send_item(MODE_ADD, 32'd660, 32'd1);
    send_item(MODE_ANCHOR, 32'd60, 32'hffffffff);
    send_item(MODE_ANCHOR, 32'd1200 * 60, 32'd0);
    send_item(MODE_ADD, 32'hffffffff, 32'd3);
    send_item(MODE_UNUSED, 32'hffffffff, 32'hffffffff);
    send_item(MODE_CLEAR, 32'd0, 32'd0);
    send_item(MODE_ADD, 32'd59, 32'd100);
    drain();

    // zero bucket length acts as one second
    write_bucket(16'd0);
    send_item(MODE_ADD, 32'd1, -32'sd5);
    send_item(MODE_ADD, 32'd64, 32'd7);
    send_item(MODE_ADD, 32'd2, 32'd9);
    send_item(MODE_ADD, 32'hffffffff, 32'd9);
    drain();

    write_bucket(16'd1);
    random_phase(300, 16'd1);
    drain();

    // receiver stalls for long while items keep coming
    write_bucket(16'hffff);
    hold_off = 1'b1;
    random_phase(20, 16'hffff);
    hold_off = 1'b0;
    random_phase(250, 16'hffff);
    drain();

    write_bucket(16'd60);
    no_gaps = 1'b1;
    random_phase(200, 16'd60);
    no_gaps = 1'b0;
    random_phase(200, 16'd60);
    drain();

    write_bucket(16'd7);
    random_phase(250, 16'd7);
    drain();

    write_bucket(16'($urandom_range(2, 65534)));
    random_phase(250, sb.bucket_len);
    drain();

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
